[rtl/bchd_pkg.sv]
// Package for the button click and hold detector.
// Holds the register map, the configuration and result structs and reset values.
// No dependencies.
package bchd_pkg;

    localparam int unsigned AddrWidth = 5;
    localparam int unsigned DataWidth = 32;
    localparam int unsigned TimeWidth = 32;
    localparam int unsigned MsWidth = 16;
    localparam int unsigned CountWidth = 8;
    localparam int unsigned InTdataWidth = 40;
    localparam int unsigned OutTdataWidth = 16;

    typedef enum logic [2:0] {
        REG_DEBOUNCE = 3'd0,
        REG_HOLD_TIMEOUT = 3'd1,
        REG_STEP_PERIOD = 3'd2,
        REG_PULL_TYPE = 3'd3,
        REG_NORMALLY_CLOSED = 3'd4
    } t_reg_index;

    localparam logic [MsWidth-1:0] DebounceReset = 16'd120;
    localparam logic [MsWidth-1:0] HoldTimeoutReset = 16'd1000;
    localparam logic [MsWidth-1:0] StepPeriodReset = 16'd400;
    localparam logic [CountWidth-1:0] CountMax = 8'd255;

    typedef struct packed {
        logic [MsWidth-1:0] debounce_ms;
        logic [MsWidth-1:0] hold_timeout_ms;
        logic [MsWidth-1:0] step_period_ms;
        logic               pull_type;
        logic               normally_closed;
    } t_cfg;

    typedef struct packed {
        logic [CountWidth-1:0] click_count;
        logic                  clicks_done;
        logic                  step_event;
        logic                  holding;
        logic                  held_event;
        logic                  click_event;
        logic                  release_event;
        logic                  press_event;
        logic                  is_pressed;
    } t_result;

endpackage

[rtl/bchd_regs.sv]
// Configuration register file of the button click and hold detector.
// APB-style write and read access; depends on bchd_pkg.
module bchd_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bchd_pkg::AddrWidth-1:0]   paddr,
    input  logic [bchd_pkg::DataWidth-1:0]   pwdata,
    output logic [bchd_pkg::DataWidth-1:0]   prdata,
    output logic                             pready,
    output bchd_pkg::t_cfg                   o_cfg
);

    bchd_pkg::t_cfg r_cfg;
    bchd_pkg::t_cfg n_cfg;
    logic           wr_en;
    logic [2:0]     reg_index;

    assign pready = 1'b1;
    assign wr_en = psel & penable & pwrite & pready;
    assign reg_index = paddr[4:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_index)
                bchd_pkg::REG_DEBOUNCE: n_cfg.debounce_ms = pwdata[15:0];
                bchd_pkg::REG_HOLD_TIMEOUT: n_cfg.hold_timeout_ms = pwdata[15:0];
                bchd_pkg::REG_STEP_PERIOD: n_cfg.step_period_ms = pwdata[15:0];
                bchd_pkg::REG_PULL_TYPE: n_cfg.pull_type = pwdata[0];
                bchd_pkg::REG_NORMALLY_CLOSED: n_cfg.normally_closed = pwdata[0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            bchd_pkg::REG_DEBOUNCE: prdata = {16'd0, r_cfg.debounce_ms};
            bchd_pkg::REG_HOLD_TIMEOUT: prdata = {16'd0, r_cfg.hold_timeout_ms};
            bchd_pkg::REG_STEP_PERIOD: prdata = {16'd0, r_cfg.step_period_ms};
            bchd_pkg::REG_PULL_TYPE: prdata = {31'd0, r_cfg.pull_type};
            bchd_pkg::REG_NORMALLY_CLOSED: prdata = {31'd0, r_cfg.normally_closed};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms <= bchd_pkg::DebounceReset;
            r_cfg.hold_timeout_ms <= bchd_pkg::HoldTimeoutReset;
            r_cfg.step_period_ms <= bchd_pkg::StepPeriodReset;
            r_cfg.pull_type <= 1'b0;
            r_cfg.normally_closed <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/bchd_core.sv]
// Per-poll detector logic and its state registers.
// Evaluates press, release, hold, sequence end and step in one pass; depends on bchd_pkg.
module bchd_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  logic                             i_pin_level,
    input  logic [bchd_pkg::TimeWidth-1:0]   i_now_ms,
    input  bchd_pkg::t_cfg                   i_cfg,
    output bchd_pkg::t_result                o_result
);

    logic                              r_press_latched;
    logic                              r_hold_latched;
    logic                              r_stepping;
    logic                              r_click_pending;
    logic [bchd_pkg::TimeWidth-1:0]    r_event_time;
    logic [bchd_pkg::CountWidth-1:0]   r_press_count;
    logic [bchd_pkg::CountWidth-1:0]   r_finished_count;

    logic                              n_press_latched;
    logic                              n_hold_latched;
    logic                              n_stepping;
    logic                              n_click_pending;
    logic [bchd_pkg::TimeWidth-1:0]    n_event_time;
    logic [bchd_pkg::CountWidth-1:0]   n_press_count;
    logic [bchd_pkg::CountWidth-1:0]   n_finished_count;

    logic [bchd_pkg::TimeWidth-1:0]    diff;
    logic                              pressed;
    logic                              ev_press;
    logic                              ev_release;
    logic                              ev_click;
    logic                              ev_held;
    logic                              ev_done;
    logic                              ev_step;
    logic                              time_now_1;
    logic                              time_now_2;
    logic                              time_now_3;
    logic                              hold_el_2;
    logic                              hold_el_3;
    logic                              step_el;
    logic                              cp_1;
    logic [bchd_pkg::CountWidth-1:0]   cnt_1;
    logic [bchd_pkg::CountWidth-1:0]   cnt_3;
    logic                              pl_2;
    logic                              hl_2;
    logic                              st_2;
    logic                              st_3;
    logic                              cp_2;

    // Within a poll the event time is either the stored value or the current
    // timestamp, so one subtract serves every compare; a fresh event gives zero.
    assign diff = i_now_ms - r_event_time;
    assign pressed = ~i_pin_level ^ i_cfg.pull_type ^ i_cfg.normally_closed;

    always_comb begin
        ev_press = pressed & ~r_press_latched
                   & (diff >= {16'd0, i_cfg.debounce_ms});
        cnt_1 = (ev_press && r_press_count != bchd_pkg::CountMax)
                ? r_press_count + 8'd1 : r_press_count;
        cp_1 = r_click_pending | ev_press;
        time_now_1 = ev_press;

        ev_release = ~pressed & r_press_latched;
        ev_click = ev_release & cp_1;
        pl_2 = ev_release ? 1'b0 : (r_press_latched | ev_press);
        hl_2 = ev_release ? 1'b0 : r_hold_latched;
        st_2 = ev_release ? 1'b0 : r_stepping;
        cp_2 = ev_release ? 1'b0 : cp_1;
        time_now_2 = time_now_1 | ev_release;

        hold_el_2 = time_now_2 ? (i_cfg.hold_timeout_ms == '0)
                               : (diff >= {16'd0, i_cfg.hold_timeout_ms});
        ev_held = pl_2 & pressed & ~hl_2 & hold_el_2;
        cnt_3 = ev_held ? '0 : cnt_1;
        st_3 = st_2 | ev_held;
        time_now_3 = time_now_2 | ev_held;

        hold_el_3 = time_now_3 ? (i_cfg.hold_timeout_ms == '0)
                               : (diff >= {16'd0, i_cfg.hold_timeout_ms});
        ev_done = hold_el_3 & (cnt_3 != '0);

        step_el = time_now_3 ? (i_cfg.step_period_ms == '0)
                             : (diff >= {16'd0, i_cfg.step_period_ms});
        ev_step = st_3 & step_el;

        n_press_latched = pl_2;
        n_hold_latched = hl_2 | ev_held;
        n_stepping = st_3;
        n_click_pending = cp_2 & ~ev_held;
        n_press_count = ev_done ? '0 : cnt_3;
        n_finished_count = ev_done ? cnt_3 : r_finished_count;
        n_event_time = (time_now_3 | ev_step) ? i_now_ms : r_event_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_latched <= 1'b0;
            r_hold_latched <= 1'b0;
            r_stepping <= 1'b0;
            r_click_pending <= 1'b0;
            r_event_time <= '0;
            r_press_count <= '0;
            r_finished_count <= '0;
        end else if (i_fire) begin
            r_press_latched <= n_press_latched;
            r_hold_latched <= n_hold_latched;
            r_stepping <= n_stepping;
            r_click_pending <= n_click_pending;
            r_event_time <= n_event_time;
            r_press_count <= n_press_count;
            r_finished_count <= n_finished_count;
        end
    end

    always_comb begin
        o_result.is_pressed = pressed;
        o_result.press_event = ev_press;
        o_result.release_event = ev_release;
        o_result.click_event = ev_click;
        o_result.held_event = ev_held;
        o_result.holding = st_3;
        o_result.step_event = ev_step;
        o_result.clicks_done = ev_done;
        o_result.click_count = n_finished_count;
    end

endmodule

[rtl/button_click_hold_detector.sv]
// Top level of the button click and hold detector.
// Input word register, output word register; uses bchd_pkg, bchd_regs and bchd_core.
//
// The block takes one poll word per clock cycle unless the output side stalls and
// returns one result word for each: the word waits in the input register, then the
// detector logic writes its result to the output register. The two registers let a
// new word enter while a finished result still waits to be taken, so a stream with
// no output stall runs at one word per cycle. The user must write configuration via
// the APB-style port while no word is in flight; the block does not enforce this.
module button_click_hold_detector (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0: pin_level [0], now_ms [32:1], zero padding [39:33].
    input  logic [bchd_pkg::InTdataWidth-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0: is_pressed, press_event, release_event, click_event,
    // held_event, holding, step_event, clicks_done, click_count [15:8].
    output logic [bchd_pkg::OutTdataWidth-1:0]    m_axis_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bchd_pkg::AddrWidth-1:0]        paddr,
    input  logic [bchd_pkg::DataWidth-1:0]        pwdata,
    output logic [bchd_pkg::DataWidth-1:0]        prdata,
    output logic                                  pready
);

    logic                              r_in_valid;
    logic                              r_in_pin;
    logic [bchd_pkg::TimeWidth-1:0]    r_in_now;
    logic                              r_out_valid;
    bchd_pkg::t_result                 r_out;
    logic                              fire;
    logic                              in_take;
    bchd_pkg::t_cfg                    cfg;
    bchd_pkg::t_result                 result;

    bchd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bchd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_pin_level (r_in_pin),
        .i_now_ms    (r_in_now),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    assign fire = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | fire;
    assign in_take = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pin <= s_axis_tdata[0];
            r_in_now <= s_axis_tdata[32:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out;

endmodule
